// ===== sv/assert_macros.svh =====
// Assertion macros shared by the conversion block RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Concurrent check on every rising clock edge, off while in reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed: lbl");
// Next-cycle implication: when ante holds, cons holds in the following cycle.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: lbl");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/esc_pkg.sv =====
// Types, constants, microcode ROM and helpers for the epoch-to-calendar block.
`timescale 1ns / 1ps
`default_nettype none
package esc_pkg;

  localparam int unsigned PC_W      = 4;
  localparam int unsigned IN_W      = 32;
  localparam int unsigned OUT_W     = 48;
  localparam int unsigned REM_W     = 17;
  localparam int unsigned DAYS_W    = 16;
  localparam int unsigned MUL_A_W   = 25;
  localparam int unsigned MUL_B_W   = 26;
  localparam int unsigned PROD_W    = MUL_A_W + MUL_B_W;

  localparam logic [REM_W-1:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [REM_W-1:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [REM_W-1:0] SECS_PER_MIN  = 17'd60;

  // Reciprocals after dropping the power-of-two factor of each divisor:
  // 86400 = 675 << 7, 3600 = 225 << 4, 60 = 15 << 2
  localparam logic [MUL_B_W-1:0] RECIP_DAY  = 26'd50903317;  // ceil(2^35 / 675)
  localparam logic [MUL_B_W-1:0] RECIP_HOUR = 26'd9321;      // ceil(2^21 / 225)
  localparam logic [MUL_B_W-1:0] RECIP_MIN  = 26'd1093;      // ceil(2^14 / 15)

  localparam logic [11:0] BASE_YEAR     = 12'd1970;
  localparam logic [1:0]  BASE_MOD4     = 2'd2;
  localparam logic [6:0]  BASE_MOD100   = 7'd70;
  localparam logic [8:0]  BASE_MOD400   = 9'd370;
  localparam logic [2:0]  BASE_WEEKDAY  = 3'd4;   // 1970-01-01 was a Thursday
  localparam logic [8:0]  DAYS_PLAIN    = 9'd365;
  localparam logic [8:0]  DAYS_LEAP     = 9'd366;
  localparam logic [3:0]  LAST_MONTH    = 4'd11;

  typedef enum logic [3:0] {
    OP_IDLE, OP_DIV, OP_SAVE_DAYS, OP_SAVE_HOUR, OP_SAVE_MIN,
    OP_YEAR, OP_MONTH, OP_NOP, OP_WRITE
  } op_t;

  typedef enum logic [1:0] {DS_DAY, DS_HOUR, DS_MIN} dsel_t;

  typedef enum logic [2:0] {
    C_NEVER, C_ALWAYS, C_NO_START, C_YEAR_MORE, C_MON_MORE, C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t   op;
    dsel_t dsel;
  } dp_ctrl_t;

  typedef struct packed {
    logic year_more;
    logic mon_more;
    logic out_busy;
  } dp_stat_t;

  typedef struct packed {
    dp_ctrl_t          ctrl;
    cond_t             cond;
    logic [PC_W-1:0]   target;
  } uword_t;

  localparam logic [PC_W-1:0] PC_IDLE     = 4'd0;
  localparam logic [PC_W-1:0] PC_DIV_DAY  = 4'd1;
  localparam logic [PC_W-1:0] PC_YEAR     = 4'd7;
  localparam logic [PC_W-1:0] PC_MONTH    = 4'd8;
  localparam logic [PC_W-1:0] PC_WAIT     = 4'd9;
  localparam logic [PC_W-1:0] PC_LAST     = 4'd10;

  // Microprogram: goto target when cond holds, else step to pc+1.
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      4'd0:    w = '{'{OP_IDLE,      DS_DAY},  C_NO_START,  PC_IDLE};
      4'd1:    w = '{'{OP_DIV,       DS_DAY},  C_NEVER,     PC_IDLE};
      4'd2:    w = '{'{OP_SAVE_DAYS, DS_DAY},  C_NEVER,     PC_IDLE};
      4'd3:    w = '{'{OP_DIV,       DS_HOUR}, C_NEVER,     PC_IDLE};
      4'd4:    w = '{'{OP_SAVE_HOUR, DS_HOUR}, C_NEVER,     PC_IDLE};
      4'd5:    w = '{'{OP_DIV,       DS_MIN},  C_NEVER,     PC_IDLE};
      4'd6:    w = '{'{OP_SAVE_MIN,  DS_MIN},  C_NEVER,     PC_IDLE};
      4'd7:    w = '{'{OP_YEAR,      DS_DAY},  C_YEAR_MORE, PC_YEAR};
      4'd8:    w = '{'{OP_MONTH,     DS_DAY},  C_MON_MORE,  PC_MONTH};
      4'd9:    w = '{'{OP_NOP,       DS_DAY},  C_OUT_BUSY,  PC_WAIT};
      4'd10:   w = '{'{OP_WRITE,     DS_DAY},  C_ALWAYS,    PC_IDLE};
      default: w = '{'{OP_NOP,       DS_DAY},  C_ALWAYS,    PC_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic [REM_W-1:0] divisor(input dsel_t d);
    logic [REM_W-1:0] v;
    case (d)
      DS_DAY:  v = SECS_PER_DAY;
      DS_HOUR: v = SECS_PER_HOUR;
      DS_MIN:  v = SECS_PER_MIN;
      default: v = SECS_PER_DAY;
    endcase
    return v;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] v;
    case (mon)
      4'd1:                      v = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   v = 5'd30;
      default:                   v = 5'd31;
    endcase
    return v;
  endfunction

  function automatic logic [2:0] mod7(input logic [5:0] v);
    logic [5:0] x;
    x = v;
    for (int i = 0; i < 8; i++) begin
      if (x >= 6'd7) x = x - 6'd7;
    end
    return x[2:0];
  endfunction

endpackage
`default_nettype wire

// ===== sv/esc_seq.sv =====
// Microcode sequencer: step counter, control ROM and jump logic.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module esc_seq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  input  wire esc_pkg::dp_stat_t stat,
  output esc_pkg::dp_ctrl_t      ctrl,
  output logic                   idle
);
  import esc_pkg::*;

  logic [PC_W-1:0] pc_r, pc_nxt;
  uword_t          uw;
  logic            take;

  always_comb begin
    uw = ucode(pc_r);
    case (uw.cond)
      C_NEVER:     take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NO_START:  take = !in_tvalid;
      C_YEAR_MORE: take = stat.year_more;
      C_MON_MORE:  take = stat.mon_more;
      C_OUT_BUSY:  take = stat.out_busy;
      default:     take = 1'b0;
    endcase
    pc_nxt = take ? uw.target : pc_r + 1'b1;
  end

  assign ctrl = uw.ctrl;
  assign idle = (uw.ctrl.op == OP_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  `ASSERT_NXT(a_start_div, clk, rst_n, idle && in_tvalid, pc_r == PC_DIV_DAY)
  `ASSERT_CLK(a_pc_range, clk, rst_n, pc_r <= PC_LAST)
  `ASSERT_NXT(a_write_return, clk, rst_n, pc_r == PC_LAST, pc_r == PC_IDLE)

endmodule
`default_nettype wire

// ===== sv/esc_dp.sv =====
// Datapath: reciprocal-multiply division, year/month walk, weekday and output register.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module esc_dp (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire esc_pkg::dp_ctrl_t         ctrl,
  output esc_pkg::dp_stat_t              stat,
  input  wire logic                      in_tvalid,
  input  wire logic [esc_pkg::IN_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [esc_pkg::OUT_W-1:0]      out_tdata
);
  import esc_pkg::*;

  logic [IN_W-1:0]   num_r, num_nxt;     // current dividend
  logic [DAYS_W-1:0] q_r, q_nxt;         // current quotient
  logic [DAYS_W-1:0] days_r, days_nxt;
  logic [4:0]        hour_r, hour_nxt;
  logic [5:0]        min_r, min_nxt;
  logic [5:0]        sec_r, sec_nxt;
  logic [11:0]       year_r, year_nxt;
  logic [1:0]        m4_r, m4_nxt;
  logic [6:0]        m100_r, m100_nxt;
  logic [8:0]        m400_r, m400_nxt;
  logic [3:0]        mon_r, mon_nxt;
  logic [2:0]        wd_r, wd_nxt;
  logic              ov_r, ov_nxt;
  logic [OUT_W-1:0]  od_r, od_nxt;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;
  logic [DAYS_W-1:0]  quo;
  logic [IN_W-1:0]    rem;
  logic              leap;
  logic [8:0]        ylen;
  logic [4:0]        mlen;
  logic              year_ge, mon_ge;
  logic [4:0]        dom;

  always_comb begin
    // floor(n / (k << s)) = ((n >> s) * ceil(2^p / k)) >> p over the dividend range
    case (ctrl.dsel)
      DS_HOUR: begin
        mul_a = {12'd0, num_r[16:4]};
        mul_b = RECIP_HOUR;
      end
      DS_MIN: begin
        mul_a = {15'd0, num_r[11:2]};
        mul_b = RECIP_MIN;
      end
      default: begin
        mul_a = num_r[31:7];
        mul_b = RECIP_DAY;
      end
    endcase
    prod = {26'd0, mul_a} * {25'd0, mul_b};
    case (ctrl.dsel)
      DS_HOUR: quo = {10'd0, prod[26:21]};
      DS_MIN:  quo = {9'd0, prod[20:14]};
      default: quo = prod[50:35];
    endcase
    rem     = num_r - ({16'd0, q_r} * {15'd0, divisor(ctrl.dsel)});

    leap    = ((m4_r == 2'd0) && (m100_r != 7'd0)) || (m400_r == 9'd0);
    ylen    = leap ? DAYS_LEAP : DAYS_PLAIN;
    mlen    = month_len(mon_r, leap);
    year_ge = (days_r >= {7'd0, ylen});
    mon_ge  = (mon_r != LAST_MONTH) && (days_r >= {11'd0, mlen});
    dom     = days_r[4:0] + 5'd1;

    num_nxt  = num_r;  q_nxt    = q_r;
    days_nxt = days_r; hour_nxt = hour_r; min_nxt  = min_r;  sec_nxt = sec_r;
    year_nxt = year_r; m4_nxt   = m4_r;   m100_nxt = m100_r; m400_nxt = m400_r;
    mon_nxt  = mon_r;  wd_nxt   = wd_r;   od_nxt   = od_r;
    ov_nxt   = ov_r && !out_tready;

    case (ctrl.op)
      OP_IDLE: begin
        if (in_tvalid) begin
          num_nxt = in_tdata;
        end
      end
      OP_DIV: begin
        q_nxt = quo;
      end
      OP_SAVE_DAYS: begin
        days_nxt = q_r;
        num_nxt  = rem;
      end
      OP_SAVE_HOUR: begin
        hour_nxt = q_r[4:0];
        num_nxt  = rem;
      end
      OP_SAVE_MIN: begin
        min_nxt  = q_r[5:0];
        sec_nxt  = rem[5:0];
        year_nxt = BASE_YEAR;
        m4_nxt   = BASE_MOD4;
        m100_nxt = BASE_MOD100;
        m400_nxt = BASE_MOD400;
        mon_nxt  = '0;
        wd_nxt   = BASE_WEEKDAY;
      end
      OP_YEAR: begin
        if (year_ge) begin
          days_nxt = days_r - {7'd0, ylen};
          year_nxt = year_r + 12'd1;
          m4_nxt   = m4_r + 2'd1;
          m100_nxt = (m100_r == 7'd99) ? 7'd0 : m100_r + 7'd1;
          m400_nxt = (m400_r == 9'd399) ? 9'd0 : m400_r + 9'd1;
          wd_nxt   = mod7({3'd0, wd_r} + (leap ? 6'd2 : 6'd1));
        end
      end
      OP_MONTH: begin
        if (mon_ge) begin
          days_nxt = days_r - {11'd0, mlen};
          mon_nxt  = mon_r + 4'd1;
          wd_nxt   = mod7({3'd0, wd_r} + {1'b0, mlen});
        end
      end
      OP_WRITE: begin
        od_nxt = {7'd0, mod7({3'd0, wd_r} + {1'b0, days_r[4:0]}), sec_r, min_r,
                  hour_r, dom, mon_r + 4'd1, year_r};
        ov_nxt = 1'b1;
      end
      OP_NOP: begin
      end
      default: begin
      end
    endcase
  end

  assign stat = '{year_ge, mon_ge, ov_r && !out_tready};

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
    end
    num_r  <= num_nxt;  q_r    <= q_nxt;
    days_r <= days_nxt; hour_r <= hour_nxt; min_r  <= min_nxt;  sec_r <= sec_nxt;
    year_r <= year_nxt; m4_r   <= m4_nxt;   m100_r <= m100_nxt; m400_r <= m400_nxt;
    mon_r  <= mon_nxt;  wd_r   <= wd_nxt;   od_r   <= od_nxt;
  end

  `ASSERT_CLK(a_write_empty, clk, rst_n, !(ctrl.op == OP_WRITE) || !ov_r)
  `ASSERT_CLK(a_month_days, clk, rst_n, !(ctrl.op == OP_MONTH) || (days_r < 16'd366))
  `ASSERT_NXT(a_year_stop, clk, rst_n, (ctrl.op == OP_YEAR) && !year_ge,
              ctrl.op == OP_MONTH)

endmodule
`default_nettype wire

// ===== sv/epoch_seconds_to_calendar.sv =====
// Epoch seconds to Gregorian date/time; the year/month walk steps once per year
// past 1970 and once per month past January of the final year.
// One word at a time: a new word is accepted only while the sequencer is idle.
// The work is reciprocal-multiply division and the year/month walk.
// A finished result waits in the output register while the next word is accepted;
// the next result holds in the sequencer until it leaves. Sync active-low reset idles all.
`timescale 1ns / 1ps
`default_nettype none
module epoch_seconds_to_calendar (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] epoch_seconds
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata   // year[11:0] month[15:12] day_of_month[20:16]
                                       // hour[25:21] minute[31:26] second[37:32]
                                       // weekday[40:38], zero pad above
);
  import esc_pkg::*;

  dp_ctrl_t ctrl;
  dp_stat_t stat;
  logic     idle;

  esc_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .stat      (stat),
    .ctrl      (ctrl),
    .idle      (idle)
  );

  esc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .stat       (stat),
    .in_tvalid  (in_tvalid),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  assign in_tready = idle;

endmodule
`default_nettype wire

// ===== sim/epoch_seconds_to_calendar_tb.sv =====
// Self-checking testbench for epoch_seconds_to_calendar: stream stimulus, date predictor.
`timescale 1ns / 1ps
module epoch_seconds_to_calendar_tb;

  localparam int CYCLE_LIMIT = 2500000;
  localparam int TAIL_CYCLES = 250;      // a bit over the worst-case latency of one word
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  mday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
  } cal_date_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;

  cal_date_t pending_dates[$];
  int        words_sent;
  int        dates_checked;
  int        fail_count;
  int        cycle_count;
  int        hold_request;
  bit        no_idle;

  epoch_seconds_to_calendar DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d dates still due", cycle_count,
               pending_dates.size());
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // m is 1-based
  function automatic int unsigned days_in_month(input int unsigned m, input bit leap);
    if (m == 2) return leap ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  function automatic cal_date_t calendar_of(input logic [31:0] secs);
    cal_date_t    c;
    int unsigned  days, tod, yr, mon, ylen, y, m, d;
    bit           leap;
    days = secs / 86400;
    tod  = secs % 86400;
    yr   = 1970;
    forever begin
      ylen = leap_year(yr) ? 366 : 365;
      if (days < ylen) break;
      days -= ylen;
      yr++;
    end
    leap = leap_year(yr);
    mon  = 1;
    while (mon < 12 && days >= days_in_month(mon, leap)) begin
      days -= days_in_month(mon, leap);
      mon++;
    end
    // Jan/Feb count as months 13/14 of the previous year
    y = yr;
    m = mon;
    d = days + 1;
    if (m < 3) begin
      m += 12;
      y -= 1;
    end
    c.year    = yr[11:0];
    c.month   = mon[3:0];
    c.mday    = d[4:0];
    c.hour    = 5'(tod / 3600);
    c.minute  = 6'((tod % 3600) / 60);
    c.second  = 6'(tod % 60);
    c.weekday = 3'((d + 1 + 2 * m + (3 * (m + 1)) / 5 + y + (y >> 2) - y / 100 + y / 400) % 7);
    return c;
  endfunction

  // days from 1970-01-01 to the first of month m of year y
  function automatic longint unsigned days_before(input int unsigned y, input int unsigned m);
    longint unsigned n;
    int unsigned     i;
    n = 0;
    for (i = 1970; i < y; i++) n += leap_year(i) ? 366 : 365;
    for (i = 1; i < m; i++) n += days_in_month(i, leap_year(y));
    return n;
  endfunction

  // ---------------------------------------------------------------- sender

  // Leaves in_tvalid high on return; the next call or a drain settles it in the same step.
  task automatic send_epoch(input logic [31:0] secs);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= secs;
    do @(posedge clk); while (!in_tready);
    pending_dates.push_back(calendar_of(secs));
    words_sent++;
  endtask

  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- receiver / checker

  task automatic compare_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  initial begin
    int        stall;
    cal_date_t want;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 12);
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      if (pending_dates.size() == 0) begin
        $error("result word 0x%012h with no date pending", out_tdata);
        fail_count++;
      end else begin
        want = pending_dates.pop_front();
        compare_field("year",         want.year,    out_tdata[11:0]);
        compare_field("month",        want.month,   out_tdata[15:12]);
        compare_field("day_of_month", want.mday,    out_tdata[20:16]);
        compare_field("hour",         want.hour,    out_tdata[25:21]);
        compare_field("minute",       want.minute,  out_tdata[31:26]);
        compare_field("second",       want.second,  out_tdata[37:32]);
        compare_field("weekday",      want.weekday, out_tdata[40:38]);
        dates_checked++;
      end
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_directed();
    send_epoch(32'd0);            // day zero, a Thursday
    send_epoch(32'd1);
    send_epoch(32'd59);
    send_epoch(32'd60);
    send_epoch(32'd3599);
    send_epoch(32'd3600);
    send_epoch(32'd86399);
    send_epoch(32'd86400);
    send_epoch(32'd31535999);     // end of 1970
    send_epoch(32'd68169600);     // 1972-02-29, first leap day
    send_epoch(32'd94694399);     // last second of a leap year
    send_epoch(32'd946684799);    // last second of 1999
    send_epoch(32'd951782400);    // 2000-02-29, century divisible by 400
    send_epoch(32'd951868800);    // 2000-03-01
    send_epoch(32'd978220800);    // 2000-12-31
    send_epoch(32'h7FFF_FFFF);
    send_epoch(32'h8000_0000);
    send_epoch(32'd4107456000);   // 2100-02-28, century that is not leap
    send_epoch(32'd4107542400);   // 2100-03-01
    send_epoch(32'hFFFF_FFFE);
    send_epoch(32'hFFFF_FFFF);    // top of range, 2106-02-07
    send_epoch(32'hAAAA_AAAA);
    send_epoch(32'h5555_5555);
    wait_for_drain();
  endtask

  // Stall the result side for a long stretch while words keep coming.
  task automatic test_backpressure();
    no_idle = 1'b1;
    hold_request = HOLD_CYCLES;
    repeat (30) send_epoch($urandom());
    no_idle = 1'b0;
    wait_for_drain();
  endtask

  task automatic test_random_epochs(input int count);
    longint unsigned s;
    int unsigned     y, m, pick;
    longint unsigned d;
    repeat (count) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        s = $urandom();
      end else begin
        if (pick < 7) begin
          d = $urandom_range(0, 49710);
        end else begin
          // around a month or year boundary
          y = $urandom_range(1970, 2106);
          m = ($urandom_range(0, 2) == 0) ? 1 : $urandom_range(1, 12);
          d = days_before(y, m);
          if (d > 0 && $urandom_range(0, 1) == 1) d -= 1;
        end
        case ($urandom_range(0, 3))
          0: s = d * 86400;
          1: s = d * 86400 + 86399;
          default: s = d * 86400 + $urandom_range(0, 86399);
        endcase
        if (s > 64'hFFFF_FFFF) s = 64'hFFFF_FFFF - $urandom_range(0, 86400 * 60);
      end
      send_epoch(s[31:0]);
    end
  endtask

  task automatic test_back_to_back(input int count);
    no_idle = 1'b1;
    repeat (count) send_epoch($urandom());
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_tvalid    <= 1'b0;
    in_tdata     <= '0;
    cycle_count  = 0;
    words_sent   = 0;
    dates_checked = 0;
    fail_count   = 0;
    hold_request = 0;
    no_idle      = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_backpressure();
    test_random_epochs(1700);
    test_back_to_back(150);
    test_random_epochs(50);

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("checked %0d of %0d epoch words: range edges, leap and century years,",
             dates_checked, words_sent);
    $display("month/year boundaries, long output stall, back-to-back and random words");
    if (fail_count == 0 && pending_dates.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
